@@ rtl/mfw_pkg.sv @@
// ----------------------------------------------------------------------------
// mfw_pkg: shared constants and types of the median filter window
// Window geometry, frame limits, field widths and configuration register
// indexes used by the line buffer, the median unit and the top level.
// ----------------------------------------------------------------------------
package mfw_pkg;

  // Window geometry
  localparam int unsigned WINDOW = 3;
  localparam int unsigned OFFSET = (WINDOW - 1) / 2;
  localparam int unsigned LINES  = WINDOW - 1;
  localparam int unsigned TAPS   = WINDOW * WINDOW;
  localparam int unsigned MID    = (TAPS - 1) / 2;

  // Frame limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Field and register widths
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned COL_W        = 10;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam int unsigned SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned RANK_W = $clog2(TAPS);

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 0,
    REG_FRAME_HEIGHT = 1
  } cfg_reg_e;

endpackage

@@ rtl/median_filter_window.sv @@
// ----------------------------------------------------------------------------
// median_filter_window: streaming square-window median filter
// Stages: a pixel is registered through the line buffer read, the window
// shift and the result register before its results are presented.
// Throughput: one pixel per cycle while out_stall_i is low; a pixel with two
// results holds the output register for two transactions, set by the single result port.
// Reset: counters and window cleared, size registers set to 640 x 480 at once;
// line buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module median_filter_window (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mfw_pkg::PIX_W-1:0]       pixel_in_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mfw_pkg::PIX_W-1:0]       pixel_out_o,
  output logic [mfw_pkg::ROW_W-1:0]       out_row_o,
  output logic [mfw_pkg::COL_W-1:0]       out_col_o,
  output logic                            last_of_item_o,
  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mfw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned WW = mfw_pkg::WIDTH_REG_W;
  localparam int unsigned HW = mfw_pkg::HEIGHT_REG_W;

  // --------------------------------------------------------------------------
  // Configuration registers, always ready
  // --------------------------------------------------------------------------
  logic [WW-1:0] frame_width_q;
  logic [HW-1:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WW'(640);
      frame_height_q <= HW'(480);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mfw_pkg::cfg_reg_e'(cfg_index_i))
        mfw_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[WW-1:0];
        mfw_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // Effective size: zero acts as one, oversize saturates
  logic [WW-1:0] wd;
  logic [HW-1:0] ht;

  assign wd = (frame_width_q == '0) ? WW'(1) :
              (frame_width_q > WW'(mfw_pkg::MAX_WIDTH)) ? WW'(mfw_pkg::MAX_WIDTH) :
              frame_width_q;
  assign ht = (frame_height_q == '0) ? HW'(1) :
              (frame_height_q > HW'(mfw_pkg::MAX_HEIGHT)) ? HW'(mfw_pkg::MAX_HEIGHT) :
              frame_height_q;

  // --------------------------------------------------------------------------
  // Pipeline handshake: A (line read), B (window), C (result register)
  // --------------------------------------------------------------------------
  logic a_valid_q, b_valid_q;
  logic c_med_q, c_pass_q;
  logic out_fire, c_free, b_free, b_move, a_free, a_move, in_fire;

  assign out_valid_o = c_med_q | c_pass_q;
  assign out_fire    = out_valid_o && !out_stall_i;
  // C frees up when empty or when its only remaining result leaves
  assign c_free  = !out_valid_o || (out_fire && !(c_med_q && c_pass_q));
  assign b_move  = b_valid_q && c_free;
  assign b_free  = !b_valid_q || c_free;
  assign a_move  = a_valid_q && b_free;
  assign a_free  = !a_valid_q || b_free;
  assign in_stall_o = !a_free;
  assign in_fire    = in_valid_i && a_free;

  // --------------------------------------------------------------------------
  // Position tracking: pre-adjust for size changes, then advance
  // --------------------------------------------------------------------------
  logic [mfw_pkg::ROW_W-1:0]  row_q, row_d, cur_row;
  logic [mfw_pkg::COL_W-1:0]  col_q, col_d, cur_col;
  logic [mfw_pkg::SLOT_W-1:0] slot_q, slot_d, cur_slot;

  function automatic logic [mfw_pkg::SLOT_W-1:0] slot_inc(
    input logic [mfw_pkg::SLOT_W-1:0] s
  );
    return (s == mfw_pkg::SLOT_W'(mfw_pkg::LINES - 1)) ? '0 : s + 1'b1;
  endfunction

  always_comb begin
    logic [HW-1:0] row_x;
    logic [WW-1:0] col_x;
    // start the next row if the column is already past the width
    cur_col  = col_q;
    row_x    = HW'(row_q);
    cur_slot = slot_q;
    if (WW'(col_q) >= wd) begin
      cur_col  = '0;
      row_x    = HW'(row_q) + HW'(1);
      cur_slot = slot_inc(slot_q);
    end
    if (row_x >= ht) begin
      row_x    = '0;
      cur_slot = '0;
    end
    cur_row = row_x[mfw_pkg::ROW_W-1:0];

    // advance past this pixel
    col_x  = WW'(cur_col) + WW'(1);
    col_d  = col_x[mfw_pkg::COL_W-1:0];
    row_x  = HW'(cur_row);
    slot_d = cur_slot;
    if (col_x >= wd) begin
      col_d  = '0;
      row_x  = HW'(cur_row) + HW'(1);
      slot_d = slot_inc(cur_slot);
      if (row_x >= ht) begin
        row_x  = '0;
        slot_d = '0;
      end
    end
    row_d = row_x[mfw_pkg::ROW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (in_fire) begin
      row_q  <= row_d;
      col_q  <= col_d;
      slot_q <= slot_d;
    end
  end

  // Result kinds of this pixel
  logic is_med, is_pass;

  assign is_med  = (cur_row >= mfw_pkg::ROW_W'(2 * mfw_pkg::OFFSET)) &&
                   (cur_col >= mfw_pkg::COL_W'(2 * mfw_pkg::OFFSET));
  assign is_pass = (cur_row < mfw_pkg::ROW_W'(mfw_pkg::OFFSET)) ||
                   (HW'(cur_row) + HW'(mfw_pkg::OFFSET) >= ht) ||
                   (cur_col < mfw_pkg::COL_W'(mfw_pkg::OFFSET)) ||
                   (WW'(cur_col) + WW'(mfw_pkg::OFFSET) >= wd);

  // --------------------------------------------------------------------------
  // Stage A: line buffer read and pixel metadata
  // --------------------------------------------------------------------------
  mfw_pkg::pix_t               line_rd [mfw_pkg::LINES];
  mfw_pkg::pix_t               a_pix_q;
  logic [mfw_pkg::ROW_W-1:0]   a_row_q;
  logic [mfw_pkg::COL_W-1:0]   a_col_q;
  logic [mfw_pkg::SLOT_W-1:0]  a_slot_q;
  logic                        a_med_q, a_pass_q;

  mfw_line_buf u_line_buf (
    .clk_i     (clk_i),
    .en_i      (in_fire),
    .addr_i    (cur_col),
    .wr_slot_i (cur_slot),
    .wr_data_i (pixel_in_i),
    .rd_data_o (line_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_pix_q  <= pixel_in_i;
      a_row_q  <= cur_row;
      a_col_q  <= cur_col;
      a_slot_q <= cur_slot;
      a_med_q  <= is_med;
      a_pass_q <= is_pass;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: shift the window left, load the new column (oldest row on top)
  // --------------------------------------------------------------------------
  mfw_pkg::pix_t [mfw_pkg::WINDOW-1:0][mfw_pkg::WINDOW-1:0] window_q, window_d;
  mfw_pkg::pix_t             b_pix_q;
  logic [mfw_pkg::ROW_W-1:0] b_row_q;
  logic [mfw_pkg::COL_W-1:0] b_col_q;
  logic                      b_med_q, b_pass_q;

  always_comb begin
    logic [mfw_pkg::SLOT_W:0] idx;
    for (int i = 0; i < mfw_pkg::WINDOW; i++) begin
      for (int j = 0; j + 1 < mfw_pkg::WINDOW; j++) begin
        window_d[i][j] = window_q[i][j+1];
      end
    end
    for (int i = 0; i < mfw_pkg::LINES; i++) begin
      idx = (mfw_pkg::SLOT_W + 1)'(a_slot_q) + (mfw_pkg::SLOT_W + 1)'(i);
      if (idx >= (mfw_pkg::SLOT_W + 1)'(mfw_pkg::LINES)) begin
        idx = idx - (mfw_pkg::SLOT_W + 1)'(mfw_pkg::LINES);
      end
      window_d[i][mfw_pkg::WINDOW-1] = line_rd[idx[mfw_pkg::SLOT_W-1:0]];
    end
    window_d[mfw_pkg::WINDOW-1][mfw_pkg::WINDOW-1] = a_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      window_q  <= '0;
    end else begin
      if (a_move) begin
        b_valid_q <= 1'b1;
        window_q  <= window_d;
      end else if (b_move) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_pix_q  <= a_pix_q;
      b_row_q  <= a_row_q;
      b_col_q  <= a_col_q;
      b_med_q  <= a_med_q;
      b_pass_q <= a_pass_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: median of the window and the result pair
  // --------------------------------------------------------------------------
  mfw_pkg::pix_t [mfw_pkg::TAPS-1:0] taps;
  mfw_pkg::pix_t                     median;

  always_comb begin
    for (int i = 0; i < mfw_pkg::WINDOW; i++) begin
      for (int j = 0; j < mfw_pkg::WINDOW; j++) begin
        taps[i*mfw_pkg::WINDOW + j] = window_q[i][j];
      end
    end
  end

  mfw_median u_median (
    .taps_i   (taps),
    .median_o (median)
  );

  mfw_pkg::pix_t             c_med_pix_q, c_pix_q;
  logic [mfw_pkg::ROW_W-1:0] c_med_row_q, c_row_q;
  logic [mfw_pkg::COL_W-1:0] c_med_col_q, c_col_q;

  // Load a new pair, or drop the result just taken (median goes first)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_med_q  <= 1'b0;
      c_pass_q <= 1'b0;
    end else if (b_move) begin
      c_med_q  <= b_med_q;
      c_pass_q <= b_pass_q;
    end else if (out_fire) begin
      if (c_med_q) begin
        c_med_q <= 1'b0;
      end else begin
        c_pass_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      c_med_pix_q <= median;
      c_med_row_q <= b_row_q - mfw_pkg::ROW_W'(mfw_pkg::OFFSET);
      c_med_col_q <= b_col_q - mfw_pkg::COL_W'(mfw_pkg::OFFSET);
      c_pix_q     <= b_pix_q;
      c_row_q     <= b_row_q;
      c_col_q     <= b_col_q;
    end
  end

  assign pixel_out_o    = c_med_q ? c_med_pix_q : c_pix_q;
  assign out_row_o      = c_med_q ? c_med_row_q : c_row_q;
  assign out_col_o      = c_med_q ? c_med_col_q : c_col_q;
  assign last_of_item_o = !(c_med_q && c_pass_q);

endmodule

@@ rtl/mfw_line_buf.sv @@
// ----------------------------------------------------------------------------
// mfw_line_buf: line buffer banks
// One bank per buffered row. All banks are read at the same column on each
// transaction; the bank of the current row is written there with the new
// pixel, after its old value is read.
// ----------------------------------------------------------------------------
module mfw_line_buf (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [mfw_pkg::COL_W-1:0] addr_i,
  input  logic [mfw_pkg::SLOT_W-1:0] wr_slot_i,
  input  mfw_pkg::pix_t             wr_data_i,
  output mfw_pkg::pix_t             rd_data_o [mfw_pkg::LINES]
);

  for (genvar b = 0; b < mfw_pkg::LINES; b++) begin : g_bank
    mfw_pkg::pix_t bank_mem [mfw_pkg::MAX_WIDTH];
    mfw_pkg::pix_t rd_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_q <= bank_mem[addr_i];
        if (wr_slot_i == mfw_pkg::SLOT_W'(b)) begin
          bank_mem[addr_i] <= wr_data_i;
        end
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

@@ rtl/mfw_median.sv @@
// ----------------------------------------------------------------------------
// mfw_median: median of the window taps
// Rank every tap against all others (ties broken by tap position), then
// pick the tap whose rank is the middle one.
// ----------------------------------------------------------------------------
module mfw_median (
  input  mfw_pkg::pix_t [mfw_pkg::TAPS-1:0] taps_i,
  output mfw_pkg::pix_t                     median_o
);

  logic [mfw_pkg::RANK_W-1:0] rank [mfw_pkg::TAPS];

  always_comb begin
    for (int i = 0; i < mfw_pkg::TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < mfw_pkg::TAPS; j++) begin
        if ((taps_i[j] < taps_i[i]) || ((taps_i[j] == taps_i[i]) && (j < i))) begin
          rank[i] = rank[i] + mfw_pkg::RANK_W'(1);
        end
      end
    end
  end

  // Ranks form a permutation, so exactly one tap matches
  always_comb begin
    median_o = '0;
    for (int i = 0; i < mfw_pkg::TAPS; i++) begin
      if (rank[i] == mfw_pkg::RANK_W'(mfw_pkg::MID)) begin
        median_o = median_o | taps_i[i];
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the streaming median filter window
// Streams grey pixels through the filter while a scoreboard class predicts
// every median and pass-through result with its row, column and last flag.
// Frame sizes are rewritten between phases only while the filter is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CLK_HALF_NS     = 2;
  localparam int unsigned TIMEOUT_NS      = 2_000_000;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned RANDOM_PIXELS   = 300;
  localparam int unsigned MAX_REPORTS     = 40;
  localparam int unsigned PRESSURE_PHASE  = 1;

  typedef struct {
    mfw_pkg::pix_t             pixel;
    logic [mfw_pkg::ROW_W-1:0] row;
    logic [mfw_pkg::COL_W-1:0] col;
    logic                      last_of_item;
  } pixel_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the filter state, predicts results, checks the output
  // --------------------------------------------------------------------------
  class median_board;
    logic [mfw_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [mfw_pkg::HEIGHT_REG_W-1:0] height_reg;
    mfw_pkg::pix_t                    line_buf [mfw_pkg::LINES][mfw_pkg::MAX_WIDTH];
    mfw_pkg::pix_t                    win [mfw_pkg::WINDOW][mfw_pkg::WINDOW];
    int unsigned                      row_pos;
    int unsigned                      col_pos;
    pixel_result_t                    pending [$];
    int unsigned                      errors;

    function new();
      width_reg  = 640;
      height_reg = 480;
      row_pos    = 0;
      col_pos    = 0;
      errors     = 0;
      foreach (line_buf[i, j]) line_buf[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
    endfunction

    function void write_reg(mfw_pkg::cfg_reg_e idx,
                            logic [mfw_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mfw_pkg::REG_FRAME_WIDTH:  width_reg  = data[mfw_pkg::WIDTH_REG_W-1:0];
        mfw_pkg::REG_FRAME_HEIGHT: height_reg = data[mfw_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, oversize saturates
    function int unsigned clamp_size(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function mfw_pkg::pix_t window_median();
      mfw_pkg::pix_t v [mfw_pkg::TAPS];
      mfw_pkg::pix_t x;
      int            n;
      int            k;
      n = 0;
      for (int i = 0; i < mfw_pkg::WINDOW; i++) begin
        for (int j = 0; j < mfw_pkg::WINDOW; j++) begin
          x = win[i][j];
          k = n;
          while (k > 0 && v[k-1] > x) begin
            v[k] = v[k-1];
            k--;
          end
          v[k] = x;
          n++;
        end
      end
      return v[mfw_pkg::MID];
    endfunction

    // Advance the filter by one accepted pixel and queue what it produces.
    function void take_pixel(mfw_pkg::pix_t pix);
      int unsigned   wd;
      int unsigned   ht;
      int unsigned   r;
      int unsigned   c;
      pixel_result_t res [2];
      int            n;
      wd = clamp_size(width_reg, mfw_pkg::MAX_WIDTH);
      ht = clamp_size(height_reg, mfw_pkg::MAX_HEIGHT);
      n  = 0;
      // a shrunk size moves the position to the next row or a new frame
      if (col_pos >= wd) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= ht) row_pos = 0;
      r = row_pos;
      c = col_pos;
      // shift the window left, load the new column with the oldest row on top
      for (int i = 0; i < mfw_pkg::WINDOW; i++)
        for (int j = 0; j + 1 < mfw_pkg::WINDOW; j++)
          win[i][j] = win[i][j+1];
      for (int k = mfw_pkg::LINES; k >= 1; k--)
        win[mfw_pkg::LINES-k][mfw_pkg::WINDOW-1] =
          line_buf[(r + mfw_pkg::LINES - k) % mfw_pkg::LINES][c];
      win[mfw_pkg::WINDOW-1][mfw_pkg::WINDOW-1] = pix;
      line_buf[r % mfw_pkg::LINES][c] = pix;
      // the delayed interior median goes first
      if (r >= 2 * mfw_pkg::OFFSET && c >= 2 * mfw_pkg::OFFSET) begin
        res[n] = '{window_median(), mfw_pkg::ROW_W'(r - mfw_pkg::OFFSET),
                   mfw_pkg::COL_W'(c - mfw_pkg::OFFSET), 1'b0};
        n++;
      end
      if (r < mfw_pkg::OFFSET || r + mfw_pkg::OFFSET >= ht ||
          c < mfw_pkg::OFFSET || c + mfw_pkg::OFFSET >= wd) begin
        res[n] = '{pix, mfw_pkg::ROW_W'(r), mfw_pkg::COL_W'(c), 1'b0};
        n++;
      end
      if (n > 0) res[n-1].last_of_item = 1'b1;
      for (int i = 0; i < n; i++) pending.push_back(res[i]);
      col_pos++;
      if (col_pos >= wd) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= ht) row_pos = 0;
      end
    endfunction

    function void field_check(string field, int unsigned want, int unsigned got,
                              pixel_result_t exp_res);
      if (want != got) begin
        if (errors < MAX_REPORTS)
          $display("%0t: %s mismatch at row %0d col %0d: expected %0d, actual %0d",
                   $time, field, exp_res.row, exp_res.col, want, got);
        errors++;
      end
    endfunction

    function void check_result(mfw_pkg::pix_t pixel, logic [mfw_pkg::ROW_W-1:0] row,
                               logic [mfw_pkg::COL_W-1:0] col, logic last_of_item);
      pixel_result_t exp_res;
      if (pending.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual pixel %0d row %0d col %0d",
                   $time, pixel, row, col);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      field_check("pixel_out", exp_res.pixel, pixel, exp_res);
      field_check("out_row", exp_res.row, row, exp_res);
      field_check("out_col", exp_res.col, col, exp_res);
      field_check("last_of_item", exp_res.last_of_item, last_of_item, exp_res);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test; every input known from time zero
  // --------------------------------------------------------------------------
  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           in_valid_i     = 1'b0;
  logic                           in_stall_o;
  mfw_pkg::pix_t                  pixel_in_i     = '0;
  logic                           out_valid_o;
  logic                           out_stall_i    = 1'b0;
  mfw_pkg::pix_t                  pixel_out_o;
  logic [mfw_pkg::ROW_W-1:0]      out_row_o;
  logic [mfw_pkg::COL_W-1:0]      out_col_o;
  logic                           last_of_item_o;
  logic                           cfg_valid_i    = 1'b0;
  logic                           cfg_ready_o;
  logic [mfw_pkg::CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [mfw_pkg::CFG_DATA_W-1:0] cfg_data_i     = '0;

  median_filter_window dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_in_i     (pixel_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_out_o    (pixel_out_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_of_item_o (last_of_item_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  median_board board = new();

  // sender burst control, owned by the stimulus process
  int unsigned burst_left  = 0;
  bit          sender_gaps = 1'b1;

  // receiver stall control; the stimulus only raises pressure_request
  bit          pressure_request = 1'b0;
  bit          pressure_taken   = 1'b0;
  int unsigned hold_left        = 0;
  int unsigned stall_span       = 0;
  stall_mode_e stall_mode       = STALL_NONE;

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Receiver: pick a stall pattern per stretch, or hold off completely once
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (pressure_request && !pressure_taken) begin
      pressure_taken = 1'b1;
      hold_left      = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      // hold off long enough for the filter to back up into its input
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_span == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_span = $urandom_range(16, 256);
      end
      stall_span--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= (stall_span % 5 < 2);
      endcase
    end
  end

  // Check every result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(pixel_out_o, out_row_o, out_col_o, last_of_item_o);
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Drop valid, let every predicted result drain, then give interior pixels
  // that produce nothing time to leave the pipeline.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one size register; only ever done with the filter idle.
  task automatic write_reg(input mfw_pkg::cfg_reg_e idx,
                           input logic [mfw_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one pixel; insert a random gap whenever a burst runs out.
  task automatic send_pixel(input mfw_pkg::pix_t pix);
    if (sender_gaps && burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 32);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    board.take_pixel(pix);
    if (burst_left > 0) burst_left--;
  endtask

  // Mix extremes, a narrow band that forces ties, and full-range values.
  function automatic mfw_pkg::pix_t pick_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return mfw_pkg::pix_t'($urandom_range(120, 135));
      default: return mfw_pkg::pix_t'($urandom);
    endcase
  endfunction

  // Mostly small widths; zero, the maximum and raw 13-bit patterns too.
  function automatic logic [mfw_pkg::CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mfw_pkg::CFG_DATA_W'($urandom_range(0, 8191));
      2:       return mfw_pkg::CFG_DATA_W'(mfw_pkg::MAX_WIDTH);
      default: return mfw_pkg::CFG_DATA_W'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [mfw_pkg::CFG_DATA_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mfw_pkg::CFG_DATA_W'($urandom_range(0, 8191));
      2:       return mfw_pkg::CFG_DATA_W'(mfw_pkg::MAX_HEIGHT);
      3, 4:    return mfw_pkg::CFG_DATA_W'($urandom_range(11, 64));
      default: return mfw_pkg::CFG_DATA_W'($urandom_range(1, 10));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mfw_pkg::pix_t ramp [9];
    int unsigned   count;
    int unsigned   random_sent;
    int unsigned   phase;

    ramp = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h00, 8'hFF, 8'h40};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero in both size registers acts as a 1 x 1 frame: pure pass-through.
    write_reg(mfw_pkg::REG_FRAME_WIDTH, '0);
    write_reg(mfw_pkg::REG_FRAME_HEIGHT, '0);
    send_pixel(8'h00);
    send_pixel(8'hFF);

    // One 3 x 3 frame: a single median, and a pixel that yields two results.
    write_reg(mfw_pkg::REG_FRAME_WIDTH, 3);
    write_reg(mfw_pkg::REG_FRAME_HEIGHT, 3);
    foreach (ramp[i]) send_pixel(ramp[i]);

    // Small frame: every pixel lies in the border band.
    write_reg(mfw_pkg::REG_FRAME_WIDTH, 2);
    write_reg(mfw_pkg::REG_FRAME_HEIGHT, 2);
    repeat (4) send_pixel(pick_pixel());

    // Shrink the width below the current column, then the height below
    // the current row, both mid-frame. No median reads unwritten storage.
    write_reg(mfw_pkg::REG_FRAME_WIDTH, 3);
    write_reg(mfw_pkg::REG_FRAME_HEIGHT, 4);
    repeat (4) send_pixel(pick_pixel());
    write_reg(mfw_pkg::REG_FRAME_WIDTH, 1);
    repeat (3) send_pixel(pick_pixel());
    write_reg(mfw_pkg::REG_FRAME_HEIGHT, 1);
    repeat (2) send_pixel(pick_pixel());

    // Oversized width saturates to the maximum; one two-row frame, starting
    // on a frame boundary, fills every line buffer column in both slots.
    write_reg(mfw_pkg::REG_FRAME_WIDTH, '1);
    write_reg(mfw_pkg::REG_FRAME_HEIGHT, 2);
    repeat (2 * mfw_pkg::MAX_WIDTH) send_pixel(pick_pixel());

    // Random phases. Every line buffer entry is written by now, so any size
    // change at any position is safe.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_PIXELS) begin
      if (phase == PRESSURE_PHASE) begin
        // small frame, no sender gaps, receiver held off after the first pixel
        write_reg(mfw_pkg::REG_FRAME_WIDTH, 6);
        write_reg(mfw_pkg::REG_FRAME_HEIGHT, 5);
        sender_gaps = 1'b0;
        count       = 200;
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(mfw_pkg::REG_FRAME_WIDTH, pick_width());
        if ($urandom_range(0, 3) != 0) write_reg(mfw_pkg::REG_FRAME_HEIGHT, pick_height());
        sender_gaps = ($urandom_range(0, 3) != 0);
        count       = $urandom_range(1, 160);
      end
      for (int unsigned i = 0; i < count; i++) begin
        send_pixel(pick_pixel());
        if (phase == PRESSURE_PHASE && i == 0) pressure_request = 1'b1;
      end
      random_sent += count;
      phase++;
      wait_idle();
    end

    wait_idle();
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the filter hangs or results never arrive.
  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

endmodule
